FILE: rtl/batched_weight_optimizer_adam_sgd_top_assert.svh
// Assertion macros shared by the optimizer RTL.
`ifndef BATCHED_WEIGHT_OPTIMIZER_ADAM_SGD_TOP_ASSERT_SVH
`define BATCHED_WEIGHT_OPTIMIZER_ADAM_SGD_TOP_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define BWO_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define BWO_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bwo_pkg.sv
// Shared types and constants of the batched weight optimizer.
`timescale 1ns / 1ps
package bwo_pkg;

    // Configuration register indexes.
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_KIND    = 3'd0;
    localparam t_cfg_idx CFG_BATCH   = 3'd1;
    localparam t_cfg_idx CFG_LRATE   = 3'd2;
    localparam t_cfg_idx CFG_FLOOR   = 3'd3;
    localparam t_cfg_idx CFG_CEILING = 3'd4;
    localparam t_cfg_idx CFG_BETA1   = 3'd5;
    localparam t_cfg_idx CFG_BETA2   = 3'd6;
    localparam t_cfg_idx CFG_EPS     = 3'd7;

    // Fixed-point constants.
    localparam logic [32:0] ONE_Q32       = 33'h1_0000_0000;
    localparam logic [63:0] ROUND_HALF    = 64'h0000_0000_8000_0000;
    localparam logic [63:0] DELTA_CAP     = 64'h0000_0100_0000_0000;
    localparam logic [6:0]  CATCHUP_LIMIT = 7'd64;

    // Iteration counts of the shared divider and square root.
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;

    // Request to the divider: floor({hi, lo} / d), hi below d.
    typedef struct packed {
        logic        start;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] d;
    } t_div_req;

    // Request to the square root unit.
    typedef struct packed {
        logic        start;
        logic [63:0] x;
    } t_sqrt_req;

endpackage

FILE: rtl/bwo_if.sv
// Input and output stream interfaces of the batched weight optimizer.
`timescale 1ns / 1ps
interface bwo_in_if;
    logic               valid;
    logic               ready;
    logic        [31:0] update_index;
    logic signed [31:0] grad_delta;
    logic signed [31:0] weight_in;

    modport source (output valid, update_index, grad_delta, weight_in, input ready);
    modport sink (input valid, update_index, grad_delta, weight_in, output ready);
endinterface

interface bwo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] weight_out;
    logic               step_taken;

    modport source (output valid, weight_out, step_taken, input ready);
    modport sink (input valid, weight_out, step_taken, output ready);
endinterface

FILE: rtl/bwo_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
`timescale 1ns / 1ps
module bwo_mul import bwo_pkg::*; (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;

    // Product is registered: it is ready in the cycle after the operands.
    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;
endmodule

FILE: rtl/bwo_div.sv
// Restoring divider, one quotient bit per cycle, 128-bit dividend by 64-bit divisor.
`timescale 1ns / 1ps
module bwo_div import bwo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic        o_done,
    output logic [63:0] o_q
);
    localparam int CW = $clog2(DIV_STEPS);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [63:0]   r_rem;
    logic [63:0]   r_lo;
    logic [63:0]   r_d;
    logic [63:0]   r_q;
    logic [63:0]   n_shift;
    logic          n_ge;

    // Shift in the next dividend bit and try the subtraction.
    always_comb begin
        n_shift = {r_rem[62:0], r_lo[63]};
        n_ge    = r_rem[63] || (n_shift >= r_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_req.hi;
                r_lo   <= i_req.lo;
                r_d    <= i_req.d;
                r_q    <= '0;
            end else if (r_busy) begin
                r_rem <= n_ge ? (n_shift - r_d) : n_shift;
                r_lo  <= {r_lo[62:0], 1'b0};
                r_q   <= {r_q[62:0], n_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

FILE: rtl/bwo_sqrt.sv
// Bitwise integer square root of a 64-bit value, two radicand bits per cycle.
`timescale 1ns / 1ps
module bwo_sqrt import bwo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_sqrt_req   i_req,
    output logic        o_done,
    output logic [31:0] o_root
);
    localparam int CW = $clog2(SQRT_STEPS);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [63:0]   r_x;
    logic [63:0]   r_res;
    logic [63:0]   r_bit;
    logic [63:0]   n_trial;

    // Candidate to subtract in this step.
    assign n_trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_x    <= i_req.x;
                r_res  <= '0;
                r_bit  <= 64'h4000_0000_0000_0000;
            end else if (r_busy) begin
                if (r_x >= n_trial) begin
                    r_x   <= r_x - n_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(SQRT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];
endmodule

FILE: rtl/batched_weight_optimizer_adam_sgd_top.sv
// Top level: batched gradient descent / Adam weight optimizer with its sequencer.
//
//  Channel  Dir  Handshake     Payload
//  in_ch    in   valid/ready   update_index, grad_delta, weight_in
//  out_ch   out  valid/ready   weight_out, step_taken
//  cfg      in   i_cfg_we      i_cfg_idx, i_cfg_data (no read-back)
//
// A request that crosses no batch boundary makes one pass of the divider; a
// gradient descent step adds a second pass and a fraction product, and Adam
// repeats its update for each of n caught-up steps (n at most 64); all requests
// share the one divider and square root.
// The block takes no new request until the current one is in the output register.
// A result waiting at the output stalls the next request only in its S_OUT state.
// Synchronous reset restores register defaults and the optimizer state.
`timescale 1ns / 1ps
`include "batched_weight_optimizer_adam_sgd_top_assert.svh"
module batched_weight_optimizer_adam_sgd_top import bwo_pkg::*; #(
    parameter int WEIGHT_FRAC_BITS = 16,
    parameter int ACCUM_WIDTH      = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bwo_in_if.sink      in_ch,
    bwo_out_if.source   out_ch,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    localparam logic [63:0]        SMAX     = {64{1'b1}} >> (65 - ACCUM_WIDTH);
    localparam logic [63:0]        UMAX     = {64{1'b1}} >> (64 - ACCUM_WIDTH);
    localparam logic signed [64:0] SMAX65   = {1'b0, SMAX};
    localparam logic signed [63:0] SMAX_S   = SMAX;
    localparam logic [63:0]        NSMAX    = ~SMAX + 64'd1;
    localparam int                 SQ_SHIFT = 32 - WEIGHT_FRAC_BITS;

    typedef enum logic [5:0] {
        S_IDLE, S_CUR, S_AVG, S_GD,
        S_A0, S_A1, S_A2, S_A3, S_A3R, S_A4, S_A5, S_A6, S_A7, S_A8, S_A9,
        S_A10, S_A11, S_A12, S_A13,
        S_P0, S_P1, S_P2, S_P3, S_P4, S_DV, S_DQ, S_WUP,
        S_CLIP, S_OUT, S_MF0, S_MF1, S_MF2, S_DIVW, S_SQW
    } t_state;

    // Configuration registers.
    logic               r_kind;
    logic [15:0]        r_bs;
    logic [31:0]        r_lr;
    logic signed [31:0] r_wfloor;
    logic signed [31:0] r_wceil;
    logic [31:0]        r_b1;
    logic [31:0]        r_b2;
    logic [31:0]        r_eps;

    // Sequencer and optimizer state.
    t_state             r_state;
    t_state             r_ret;
    logic signed [63:0] r_sum;
    logic signed [63:0] r_m;
    logic [63:0]        r_v;
    logic [32:0]        r_p1;
    logic [32:0]        r_p2;
    logic [31:0]        r_last;
    logic [6:0]         r_n;
    logic               r_taken;
    logic               r_out_valid;

    // Working registers.
    logic signed [63:0] r_g;
    logic signed [63:0] r_w;
    logic [31:0]        r_cur;
    logic [32:0]        r_f1;
    logic [32:0]        r_f2;
    logic [32:0]        r_s2;
    logic [63:0]        r_alpha;
    logic [63:0]        r_denom;
    logic [127:0]       r_acc;
    logic [63:0]        r_t;
    logic [63:0]        r_mf_mag;
    logic [31:0]        r_mf_frac;
    logic [63:0]        r_mf_lo;
    logic [63:0]        r_mf_res;
    t_div_req           r_div;
    t_sqrt_req          r_sq;
    logic signed [31:0] r_wout;
    logic               r_step;

    // Shared unit connections.
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_mul_p;
    logic        w_div_done;
    logic [63:0] w_div_q;
    logic        w_sq_done;
    logic [31:0] w_sq_root;

    // Combinational helpers.
    logic               w_in_acc;
    logic               w_out_load;
    logic signed [63:0] w_gin;
    logic [63:0]        w_sum_next;
    logic [63:0]        w_abs_m;
    logic [63:0]        w_abs_g;
    logic [63:0]        w_abs_sum;
    logic [63:0]        w_bs64;
    logic [31:0]        w_cur;
    logic [31:0]        w_diff;
    logic [63:0]        w_avg;
    logic [63:0]        w_mf_out;
    logic signed [63:0] w_gpart;
    logic [63:0]        w_m_next;
    logic [63:0]        w_g2_raw;
    logic [63:0]        w_g2;
    logic [63:0]        w_g2n;
    logic [64:0]        w_v_sum;
    logic [63:0]        w_v_next;
    logic [63:0]        w_den;
    logic [63:0]        w_num;
    logic signed [63:0] w_ceil64;
    logic signed [63:0] w_floor64;
    logic signed [63:0] w_clip1;
    logic signed [63:0] w_clip2;

    function automatic logic [63:0] abs64(input logic signed [63:0] x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

    // Symmetric saturation to the accumulator range.
    function automatic logic [63:0] sat_sym(input logic signed [64:0] x);
        if (x > SMAX65) begin
            return SMAX;
        end else if (x < -SMAX65) begin
            return NSMAX;
        end
        return x[63:0];
    endfunction

    bwo_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    bwo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div),
        .o_done  (w_div_done),
        .o_q     (w_div_q)
    );

    bwo_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_sq),
        .o_done  (w_sq_done),
        .o_root  (w_sq_root)
    );

    // Handshakes.
    assign in_ch.ready       = (r_state == S_IDLE);
    assign w_in_acc          = in_ch.valid && in_ch.ready;
    assign w_out_load        = (r_state == S_OUT) && (!r_out_valid || out_ch.ready);
    assign out_ch.valid      = r_out_valid;
    assign out_ch.weight_out = r_wout;
    assign out_ch.step_taken = r_step;

    // Multiplier operand selection by sequencer state.
    always_comb begin
        unique case (r_state)
            S_MF0: begin
                w_mul_a = r_mf_mag[31:0];
                w_mul_b = r_mf_frac;
            end
            S_MF1: begin
                w_mul_a = r_mf_mag[63:32];
                w_mul_b = r_mf_frac;
            end
            S_A4: begin
                w_mul_a = r_lr;
                w_mul_b = r_s2[31:0];
            end
            S_A8: begin
                w_mul_a = w_abs_g[31:0];
                w_mul_b = w_abs_g[31:0];
            end
            S_P0: begin
                w_mul_a = r_alpha[31:0];
                w_mul_b = w_abs_m[31:0];
            end
            S_P1: begin
                w_mul_a = r_alpha[31:0];
                w_mul_b = w_abs_m[63:32];
            end
            S_P2: begin
                w_mul_a = r_alpha[63:32];
                w_mul_b = w_abs_m[31:0];
            end
            S_P3: begin
                w_mul_a = r_alpha[63:32];
                w_mul_b = w_abs_m[63:32];
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Datapath values used by the sequencer.
    always_comb begin
        w_gin      = {{32{in_ch.grad_delta[31]}}, in_ch.grad_delta};
        w_sum_next = sat_sym({r_sum[63], r_sum} + {w_gin[63], w_gin});
        w_abs_m    = abs64(r_m);
        w_abs_g    = abs64(r_g);
        w_abs_sum  = abs64(r_sum);
        w_bs64     = {48'd0, (r_bs == 16'd0) ? 16'd1 : r_bs};
        w_cur      = (w_div_q[31:0] == 32'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                      : w_div_q[31:0] + 32'd1;
        w_diff     = r_cur - r_last;
        w_avg      = r_sum[63] ? (~w_div_q + 64'd1) : w_div_q;
        w_mf_out   = w_mul_p + ((r_mf_lo + ROUND_HALF) >> 32);
        w_gpart    = r_g[63] ? (r_g + $signed(r_mf_res)) : (r_g - $signed(r_mf_res));
        w_m_next   = sat_sym({r_t[63], r_t} + {w_gpart[63], w_gpart});
        w_g2_raw   = (w_abs_g[63:32] != 32'd0) ? {64{1'b1}} : w_mul_p;
        w_g2       = (w_g2_raw > UMAX) ? UMAX : w_g2_raw;
        w_g2n      = r_t - r_mf_res;
        w_v_sum    = {1'b0, r_v} + {1'b0, w_g2n};
        w_v_next   = (w_v_sum > {1'b0, UMAX}) ? UMAX : w_v_sum[63:0];
        w_den      = ({32'd0, w_sq_root} << SQ_SHIFT) + {32'd0, r_eps};
        w_num      = r_s2[32] ? {r_lr, 32'd0} : w_mul_p;
        w_ceil64   = {{32{r_wceil[31]}}, r_wceil};
        w_floor64  = {{32{r_wfloor[31]}}, r_wfloor};
        w_clip1    = (r_w > w_ceil64) ? w_ceil64 : r_w;
        w_clip2    = (w_clip1 < w_floor64) ? w_floor64 : w_clip1;
    end

    // Sequencer, optimizer state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= 1'b0;
            r_bs        <= 16'd1;
            r_lr        <= 32'd429497;
            r_wfloor    <= 32'sd0;
            r_wceil     <= 32'sd6553600;
            r_b1        <= 32'd3865470566;
            r_b2        <= 32'd4290672329;
            r_eps       <= 32'd43;
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_sum       <= '0;
            r_m         <= '0;
            r_v         <= '0;
            r_p1        <= ONE_Q32;
            r_p2        <= ONE_Q32;
            r_last      <= 32'd1;
            r_n         <= '0;
            r_taken     <= 1'b0;
            r_out_valid <= 1'b0;
            r_div.start <= 1'b0;
            r_sq.start  <= 1'b0;
        end else begin
            r_div.start <= 1'b0;
            r_sq.start  <= 1'b0;

            // Register writes from the configuration port.
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_KIND:    r_kind   <= i_cfg_data[0];
                    CFG_BATCH:   r_bs     <= i_cfg_data[15:0];
                    CFG_LRATE:   r_lr     <= i_cfg_data;
                    CFG_FLOOR:   r_wfloor <= i_cfg_data;
                    CFG_CEILING: r_wceil  <= i_cfg_data;
                    CFG_BETA1:   r_b1     <= i_cfg_data;
                    CFG_BETA2:   r_b2     <= i_cfg_data;
                    CFG_EPS:     r_eps    <= i_cfg_data;
                endcase
            end

            // A taken result frees the output register.
            if (out_ch.valid && out_ch.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_g         <= w_gin;
                        r_w         <= {{32{in_ch.weight_in[31]}}, in_ch.weight_in};
                        r_sum       <= w_sum_next;
                        r_div.start <= 1'b1;
                        r_div.hi    <= '0;
                        r_div.lo    <= {32'd0, in_ch.update_index};
                        r_div.d     <= w_bs64;
                        r_ret       <= S_CUR;
                        r_state     <= S_DIVW;
                    end
                end
                // Step number of this request and batch boundary test.
                S_CUR: begin
                    r_cur <= w_cur;
                    if (r_last < w_cur) begin
                        r_taken     <= 1'b1;
                        r_div.start <= 1'b1;
                        r_div.hi    <= '0;
                        r_div.lo    <= w_abs_sum;
                        r_div.d     <= w_bs64;
                        r_ret       <= S_AVG;
                        r_state     <= S_DIVW;
                    end else begin
                        r_taken <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                // Batch average; choose the optimizer.
                S_AVG: begin
                    r_g    <= w_avg;
                    r_sum  <= '0;
                    r_last <= r_cur;
                    r_n    <= (w_diff > 32'(CATCHUP_LIMIT)) ? CATCHUP_LIMIT : w_diff[6:0];
                    if (!r_kind) begin
                        r_mf_mag  <= w_div_q;
                        r_mf_frac <= r_lr;
                        r_ret     <= S_GD;
                        r_state   <= S_MF0;
                    end else begin
                        r_state <= S_A0;
                    end
                end
                S_GD: begin
                    r_w     <= r_g[63] ? (r_w + $signed((r_mf_res > DELTA_CAP) ? DELTA_CAP
                                                                             : r_mf_res))
                                       : (r_w - $signed((r_mf_res > DELTA_CAP) ? DELTA_CAP
                                                                             : r_mf_res));
                    r_state <= S_CLIP;
                end
                // Adam: advance both decay powers.
                S_A0: begin
                    r_mf_mag  <= {31'd0, r_p1};
                    r_mf_frac <= r_b1;
                    r_ret     <= S_A1;
                    r_state   <= S_MF0;
                end
                S_A1: begin
                    r_p1      <= r_mf_res[32:0];
                    r_mf_mag  <= {31'd0, r_p2};
                    r_mf_frac <= r_b2;
                    r_ret     <= S_A2;
                    r_state   <= S_MF0;
                end
                // Bias factors.
                S_A2: begin
                    r_p2    <= r_mf_res[32:0];
                    r_f1    <= (r_p1 == ONE_Q32) ? 33'd1 : ONE_Q32 - r_p1;
                    r_f2    <= ONE_Q32 - r_mf_res[32:0];
                    r_state <= S_A3;
                end
                S_A3: begin
                    if (r_f2[32]) begin
                        r_s2    <= ONE_Q32;
                        r_state <= S_A4;
                    end else begin
                        r_sq.start <= 1'b1;
                        r_sq.x     <= {r_f2[31:0], 32'd0};
                        r_ret      <= S_A3R;
                        r_state    <= S_SQW;
                    end
                end
                S_A3R: begin
                    r_s2    <= {1'b0, w_sq_root};
                    r_state <= S_A4;
                end
                S_A4: begin
                    r_state <= S_A5;
                end
                // Step size alpha = eta * sqrt(f2) / f1.
                S_A5: begin
                    r_div.start <= 1'b1;
                    r_div.hi    <= '0;
                    r_div.lo    <= w_num;
                    r_div.d     <= {31'd0, r_f1};
                    r_ret       <= S_A6;
                    r_state     <= S_DIVW;
                end
                // First moment update.
                S_A6: begin
                    r_alpha   <= w_div_q;
                    r_mf_mag  <= w_abs_m;
                    r_mf_frac <= r_b1;
                    r_ret     <= S_A7;
                    r_state   <= S_MF0;
                end
                S_A7: begin
                    r_t       <= r_m[63] ? (~r_mf_res + 64'd1) : r_mf_res;
                    r_mf_mag  <= w_abs_g;
                    r_mf_frac <= r_b1;
                    r_ret     <= S_A8;
                    r_state   <= S_MF0;
                end
                S_A8: begin
                    r_m     <= w_m_next;
                    r_state <= S_A9;
                end
                // Second moment update.
                S_A9: begin
                    r_t       <= w_g2;
                    r_mf_mag  <= r_v;
                    r_mf_frac <= r_b2;
                    r_ret     <= S_A10;
                    r_state   <= S_MF0;
                end
                S_A10: begin
                    r_v       <= r_mf_res;
                    r_mf_mag  <= r_t;
                    r_mf_frac <= r_b2;
                    r_ret     <= S_A11;
                    r_state   <= S_MF0;
                end
                S_A11: begin
                    r_v     <= w_v_next;
                    r_state <= S_A12;
                end
                S_A12: begin
                    r_sq.start <= 1'b1;
                    r_sq.x     <= r_v;
                    r_ret      <= S_A13;
                    r_state    <= S_SQW;
                end
                S_A13: begin
                    r_denom <= (w_den == 64'd0) ? 64'd1 : w_den;
                    r_state <= S_P0;
                end
                // alpha * |m| as four partial products.
                S_P0: begin
                    r_state <= S_P1;
                end
                S_P1: begin
                    r_acc   <= {64'd0, w_mul_p};
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_acc   <= r_acc + {32'd0, w_mul_p, 32'd0};
                    r_state <= S_P3;
                end
                S_P3: begin
                    r_acc   <= r_acc + {32'd0, w_mul_p, 32'd0};
                    r_state <= S_P4;
                end
                S_P4: begin
                    r_acc   <= r_acc + {w_mul_p, 64'd0};
                    r_state <= S_DV;
                end
                // Step magnitude, saturated when the quotient cannot fit.
                S_DV: begin
                    if (r_acc[127:64] >= r_denom) begin
                        r_t     <= DELTA_CAP;
                        r_state <= S_WUP;
                    end else begin
                        r_div.start <= 1'b1;
                        r_div.hi    <= r_acc[127:64];
                        r_div.lo    <= r_acc[63:0];
                        r_div.d     <= r_denom;
                        r_ret       <= S_DQ;
                        r_state     <= S_DIVW;
                    end
                end
                S_DQ: begin
                    r_t     <= (w_div_q < DELTA_CAP) ? w_div_q : DELTA_CAP;
                    r_state <= S_WUP;
                end
                // Apply the step; later caught-up steps use a zero gradient.
                S_WUP: begin
                    r_w     <= r_m[63] ? (r_w + $signed(r_t)) : (r_w - $signed(r_t));
                    r_g     <= '0;
                    r_n     <= r_n - 7'd1;
                    r_state <= (r_n == 7'd1) ? S_CLIP : S_A0;
                end
                S_CLIP: begin
                    r_w     <= w_clip2;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_wout      <= r_w[31:0];
                        r_step      <= r_taken;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                // Rounded fraction product: low half, high half, combine.
                S_MF0: begin
                    r_state <= S_MF1;
                end
                S_MF1: begin
                    r_mf_lo <= w_mul_p;
                    r_state <= S_MF2;
                end
                S_MF2: begin
                    r_mf_res <= w_mf_out;
                    r_state  <= r_ret;
                end
                S_DIVW: begin
                    if (w_div_done) begin
                        r_state <= r_ret;
                    end
                end
                S_SQW: begin
                    if (w_sq_done) begin
                        r_state <= r_ret;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `BWO_ASSERT_IMP(a_catchup_count, r_state == S_A0, (r_n != 7'd0) && (r_n <= CATCHUP_LIMIT), "Adam step entered with a bad catch-up count")
    `BWO_ASSERT_IMP(a_power_range, 1'b1, (r_p1 <= ONE_Q32) && (r_p2 <= ONE_Q32), "Decay power above one")
    `BWO_ASSERT_IMP(a_sum_saturated, 1'b1, (r_sum <= SMAX_S) && (r_sum >= -SMAX_S), "Gradient sum outside its saturation range")
    `BWO_ASSERT_NXT(a_result_loaded, w_out_load, r_out_valid && (r_state == S_IDLE), "Result not presented after load")

endmodule

FILE: test/tb_top.sv
// Self-checking testbench of the batched gradient descent / Adam weight optimizer.
`timescale 1ns / 1ps
module tb_top;
    import bwo_pkg::*;

    localparam longint     ACC_MAX  = 64'sd140737488355327;   // 2^47 - 1
    localparam bit [63:0]  MSQ_MAX  = 64'hFFFF_FFFF_FFFF;     // 2^48 - 1
    localparam bit [63:0]  Q32_ONE  = 64'h1_0000_0000;
    localparam bit [63:0]  STEP_CAP = 64'h100_0000_0000;
    localparam int         MAX_CATCHUP = 64;

    typedef struct {
        bit [31:0]   idx;
        bit [31:0]   grad;
        bit [31:0]   wgt;
    } t_request;

    typedef struct {
        bit [31:0] wgt;
        bit        step;
    } t_weight_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    t_cfg_idx i_cfg_idx;
    logic [31:0] i_cfg_data;

    bwo_in_if  in_ch ();
    bwo_out_if out_ch ();

    batched_weight_optimizer_adam_sgd_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Optimizer settings and state as tracked by the testbench.
    bit        opt_adam;
    bit [15:0] batch_len;
    bit [31:0] eta, beta1, beta2, eps;
    longint    clip_lo, clip_hi;
    longint    grad_acc, mom1;
    bit [63:0] mom2, pow1, pow2;
    bit [31:0] prev_step;

    t_request       pending_requests[$];
    t_weight_result expected_weights[$];
    int             error_count;
    int unsigned    cycle_count;
    logic           in_fire;
    bit [63:0]      next_index;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #60ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic bit [63:0] isqrt(bit [63:0] x);
        bit [63:0] res;
        bit [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic bit [63:0] magnitude(longint x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    // Rounded product of a magnitude with a Q0.32 fraction.
    function automatic bit [63:0] scale_frac(bit [63:0] mag, bit [31:0] fr);
        bit [63:0] hi;
        bit [63:0] lo;
        hi = mag >> 32;
        lo = {32'd0, mag[31:0]};
        return hi * {32'd0, fr} + ((lo * {32'd0, fr} + 64'h8000_0000) >> 32);
    endfunction

    function automatic longint scale_frac_signed(longint x, bit [31:0] fr);
        bit [63:0] r;
        r = scale_frac(magnitude(x), fr);
        return x < 0 ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint acc_add(longint a, longint b);
        if (b > 0 && a > ACC_MAX - b) return ACC_MAX;
        if (b < 0 && a < -ACC_MAX - b) return -ACC_MAX;
        return a + b;
    endfunction

    // One bias-corrected Adam step on weight w with gradient g.
    function automatic longint adam_update(longint w, longint g);
        bit [63:0]  f1, f2, s2, alpha, gm, g2, denom, mag, hi, delta;
        bit [127:0] prod;
        pow1 = (pow1 * {32'd0, beta1} + 64'h8000_0000) >> 32;
        pow2 = (pow2 * {32'd0, beta2} + 64'h8000_0000) >> 32;
        f1 = Q32_ONE - pow1;
        if (f1 == 0) f1 = 1;
        f2 = Q32_ONE - pow2;
        s2 = (f2 >= Q32_ONE) ? Q32_ONE : isqrt(f2 << 32);
        alpha = ({32'd0, eta} * s2) / f1;

        mom1 = acc_add(scale_frac_signed(mom1, beta1), g - scale_frac_signed(g, beta1));

        gm = magnitude(g);
        g2 = (gm >= Q32_ONE) ? 64'hFFFF_FFFF_FFFF_FFFF : gm * gm;
        if (g2 > MSQ_MAX) g2 = MSQ_MAX;
        mom2 = scale_frac(mom2, beta2);
        g2 = g2 - scale_frac(g2, beta2);
        mom2 = (mom2 > MSQ_MAX - g2) ? MSQ_MAX : mom2 + g2;

        denom = (isqrt(mom2) << 16) + {32'd0, eps};
        if (denom == 0) denom = 1;
        mag = magnitude(mom1);
        prod = {64'd0, alpha} * {64'd0, mag};
        hi = prod[127:64];
        if (hi >= denom) begin
            delta = STEP_CAP;
        end else begin
            prod = prod / {64'd0, denom};
            delta = (prod[63:0] < STEP_CAP) ? prod[63:0] : STEP_CAP;
        end
        return mom1 < 0 ? w + longint'(delta) : w - longint'(delta);
    endfunction

    // Expected weight for one accepted request; advances the tracked state.
    function automatic t_weight_result predict_weight(t_request rq);
        t_weight_result res;
        longint    w, avg;
        bit [63:0] bsz, cur, nsteps, d;
        w = longint'($signed(rq.wgt));
        bsz = (batch_len == 0) ? 64'd1 : {48'd0, batch_len};
        cur = 64'd1 + {32'd0, rq.idx} / bsz;
        if (cur > 64'hFFFF_FFFF) cur = 64'hFFFF_FFFF;
        grad_acc = acc_add(grad_acc, longint'($signed(rq.grad)));
        res.step = 1'b0;
        if ({32'd0, prev_step} < cur) begin
            avg = grad_acc / longint'(bsz);
            res.step = 1'b1;
            if (!opt_adam) begin
                d = scale_frac(magnitude(avg), eta);
                if (d > STEP_CAP) d = STEP_CAP;
                w = avg < 0 ? w + longint'(d) : w - longint'(d);
            end else begin
                nsteps = cur - {32'd0, prev_step};
                if (nsteps > MAX_CATCHUP) nsteps = MAX_CATCHUP;
                for (int k = 0; k < int'(nsteps); k++) begin
                    w = adam_update(w, avg);
                    avg = 0;
                end
            end
            grad_acc = 0;
            if (w > clip_hi) w = clip_hi;
            if (w < clip_lo) w = clip_lo;
            prev_step = cur[31:0];
        end
        res.wgt = w[31:0];
        return res;
    endfunction

    // Register write, mirrored into the tracked settings.
    task automatic write_reg(t_cfg_idx idx, bit [31:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        case (idx)
            CFG_KIND:    opt_adam = data[0];
            CFG_BATCH:   batch_len = data[15:0];
            CFG_LRATE:   eta = data;
            CFG_FLOOR:   clip_lo = longint'($signed(data));
            CFG_CEILING: clip_hi = longint'($signed(data));
            CFG_BETA1:   beta1 = data;
            CFG_BETA2:   beta2 = data;
            CFG_EPS:     eps = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic push_request(bit [31:0] idx, bit [31:0] g, bit [31:0] w);
        t_request rq;
        rq.idx = idx;
        rq.grad = g;
        rq.wgt = w;
        pending_requests.push_back(rq);
    endtask

    function automatic bit [31:0] random_grad();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
        endcase
    endfunction

    function automatic bit [31:0] random_weight();
        case ($urandom_range(0, 3))
            0: return $urandom();
            default: return 32'($signed($urandom_range(0, 32'h00C8_0000)) - 32'sh0064_0000);
        endcase
    endfunction

    // Random requests: mostly one step per boundary, some multi-step gaps,
    // a few repeats and backward moves of the update index.
    task automatic push_random(int count);
        int        r;
        bit [63:0] bsz;
        bsz = (batch_len == 0) ? 64'd1 : {48'd0, batch_len};
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 45) next_index = next_index + $urandom_range(0, 1);
            else if (r < 85) next_index = next_index + bsz;
            else if (r < 93) next_index = next_index + bsz * $urandom_range(2, 4);
            else if (r < 97) next_index = next_index - ((next_index > 5) ? $urandom_range(1, 5) : 0);
            if (next_index > 64'hFFF0_0000) next_index = 64'hFFF0_0000;
            push_request(next_index[31:0], random_grad(), random_weight());
        end
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || in_ch.valid || expected_weights.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Request driver: a new item is presented after the previous one is taken.
    always @(negedge i_clk) begin
        t_request rq;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_fire) begin
            if (pending_requests.size() != 0 &&
                (cycle_count inside {[3000:9000]} || $urandom_range(0, 99) >= 27)) begin
                rq = pending_requests.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.update_index <= rq.idx;
                in_ch.grad_delta <= rq.grad;
                in_ch.weight_in <= rq.wgt;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
        out_ch.ready <= (cycle_count inside {[3000:9000]}) ? 1'b1 :
                        ($urandom_range(0, 99) >= 27);
    end

    // Acceptance tracking, prediction and result checking.
    always @(posedge i_clk) begin
        t_request       rq;
        t_weight_result exp_r;
        cycle_count <= cycle_count + 1;
        in_fire <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            rq.idx = in_ch.update_index;
            rq.grad = in_ch.grad_delta;
            rq.wgt = in_ch.weight_in;
            expected_weights.push_back(predict_weight(rq));
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_weights.size() == 0) begin
                $error("unexpected result: weight_out %0d", $signed(out_ch.weight_out));
                error_count++;
            end else begin
                exp_r = expected_weights.pop_front();
                if (out_ch.weight_out !== exp_r.wgt) begin
                    $error("weight_out: expected %0d, actual %0d",
                           $signed(exp_r.wgt), $signed(out_ch.weight_out));
                    error_count++;
                end
                if (out_ch.step_taken !== exp_r.step) begin
                    $error("step_taken: expected %0d, actual %0d", exp_r.step, out_ch.step_taken);
                    error_count++;
                end
            end
        end
    end

    // Stimulus sequence.
    initial begin
        error_count = 0;
        cycle_count = 0;
        in_fire = 1'b0;
        next_index = 0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_KIND;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.update_index = '0;
        in_ch.grad_delta = '0;
        in_ch.weight_in = '0;
        out_ch.ready = 1'b0;
        opt_adam = 0; batch_len = 1; eta = 32'd429497;
        clip_lo = 0; clip_hi = 6553600;
        beta1 = 32'd3865470566; beta2 = 32'd4290672329; eps = 32'd43;
        grad_acc = 0; mom1 = 0; mom2 = 0;
        pow1 = Q32_ONE; pow2 = Q32_ONE; prev_step = 1;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings, gradient descent: field extremes and index corners.
        push_request(32'd0, 32'h7FFF_FFFF, 32'h0000_0000);
        push_request(32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_request(32'd1, 32'h8000_0000, 32'h8000_0000);
        push_request(32'd2, 32'h8000_0000, 32'h0010_0000);
        push_request(32'd0, 32'hFFFF_FFFF, 32'h0001_0000);
        push_request(32'd3, 32'h0000_0000, 32'hFFFF_FFFF);
        push_request(32'd5, 32'h0001_0000, 32'h0064_0000);
        push_request(32'd6, 32'hFFFF_0000, 32'h0000_0001);
        next_index = 6;
        push_random(110);
        wait_idle();

        // Gradient descent, batches of four, widest learning rate and bounds.
        write_reg(CFG_BATCH, 32'hABCD_0004);
        write_reg(CFG_LRATE, 32'hFFFF_FFFF);
        write_reg(CFG_FLOOR, 32'h8000_0000);
        write_reg(CFG_CEILING, 32'h7FFF_FFFF);
        push_random(120);
        wait_idle();

        // Adam with default decays; a long gap exercises the catch-up limit.
        write_reg(CFG_KIND, 32'hFFFF_FFFF);
        write_reg(CFG_BATCH, 32'd1);
        write_reg(CFG_LRATE, 32'd42949673);
        write_reg(CFG_FLOOR, 32'hFF9C_0000);
        write_reg(CFG_CEILING, 32'h0064_0000);
        next_index = next_index + 1;
        push_request(next_index[31:0], 32'h0001_0000, 32'h0000_0000);
        next_index = next_index + 100;
        push_request(next_index[31:0], 32'h8000_0000, 32'h0010_0000);
        next_index = next_index + 3;
        push_request(next_index[31:0], 32'h7FFF_FFFF, 32'hFFF0_0000);
        push_random(130);
        wait_idle();

        // Adam with zero decays and zero epsilon: zero denominator case.
        write_reg(CFG_BATCH, 32'd3);
        write_reg(CFG_BETA1, 32'd0);
        write_reg(CFG_BETA2, 32'd0);
        write_reg(CFG_EPS, 32'd0);
        next_index = next_index + 3;
        push_request(next_index[31:0], 32'h0000_0000, 32'h0000_1000);
        push_random(120);
        wait_idle();

        // Floor above ceiling with the largest decays and epsilon.
        write_reg(CFG_BATCH, 32'd2);
        write_reg(CFG_FLOOR, 32'h03E8_0000);
        write_reg(CFG_CEILING, 32'hFC18_0000);
        write_reg(CFG_BETA1, 32'hFFFF_FFFF);
        write_reg(CFG_BETA2, 32'hFFFF_FFFF);
        write_reg(CFG_EPS, 32'hFFFF_FFFF);
        push_random(110);
        wait_idle();

        // Zero batch size is treated as one; smallest learning rate.
        write_reg(CFG_KIND, 32'd0);
        write_reg(CFG_BATCH, 32'hFFFF_0000);
        write_reg(CFG_LRATE, 32'd1);
        write_reg(CFG_FLOOR, 32'h8000_0000);
        write_reg(CFG_CEILING, 32'h7FFF_FFFF);
        push_random(110);
        wait_idle();

        // Largest batch, Adam with reset-like decays.
        write_reg(CFG_KIND, 32'd1);
        write_reg(CFG_BATCH, 32'd65535);
        write_reg(CFG_LRATE, 32'h8000_0000);
        write_reg(CFG_BETA1, 32'd3865470566);
        write_reg(CFG_BETA2, 32'd4290672329);
        write_reg(CFG_EPS, 32'd43);
        push_random(110);
        wait_idle();

        // Top of the index range, where the step count saturates.
        write_reg(CFG_KIND, 32'd0);
        write_reg(CFG_BATCH, 32'd1);
        next_index = 64'hFFFF_FFF0;
        push_request(32'hFFFF_FFF0, random_grad(), random_weight());
        push_request(32'hFFFF_FFFE, random_grad(), random_weight());
        push_request(32'hFFFF_FFFF, 32'h7FFF_FFFF, random_weight());
        push_request(32'hFFFF_FFFF, 32'h8000_0000, random_weight());
        push_request(32'hFFFF_FFFF, random_grad(), random_weight());
        wait_idle();
        repeat (400) @(posedge i_clk);

        if (error_count == 0 && expected_weights.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
